// File: src/c2p_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// cartesian-to-polar CORDIC core. No dependencies.
`default_nettype none

package c2p_pkg;

   localparam int ITERATIONS_DEFAULT = 32;

   localparam int GUARD_W = 24;                 // input Q16 -> Q40
   localparam int XY_W    = 58;                 // Q40 x/y incl. CORDIC growth
   localparam int Z_W     = 64;                 // Q60 angle accumulator
   localparam int MAG_W   = 32;
   localparam int ANG_W   = 31;

   localparam logic [Z_W-1:0]   PI_HALF_Q60 = 64'h1921FB54442D1846;
   localparam logic [MAG_W-1:0] MAG_LIMIT   = 32'd3037000500;
   localparam logic [ANG_W-1:0] ANGLE_LIMIT = 31'd843314857;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [Z_W-1:0]         z;
      logic                   zero;
      logic                   last;
   } c2p_vec_type;

   // Restoring long division, evaluated only while elaborating constants.
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // atan(2^-i) in Q60 by the alternating arctangent series.
   function automatic logic [63:0] atan_q60(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      int          prod;
      acc = '0;
      if (i == 0) begin
         acc = 64'h0C90FDAA22168C23;
      end else if (i <= 60) begin
         for (int k = 0; k < 64; k++) begin
            prod = i * (2 * k + 1);
            if (prod <= 60) begin
               term = udiv64(64'd1 << (60 - prod), 64'(2 * k + 1));
               if (k % 2 == 1) begin
                  acc = acc - term;
               end else begin
                  acc = acc + term;
               end
            end
         end
      end
      return acc;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] bitv;
      v    = val;
      r    = '0;
      bitv = 64'd1 << 62;
      for (int j = 0; j < 32; j++) begin
         if (bitv > v) begin
            bitv = bitv >> 2;
         end
      end
      for (int j = 0; j < 32; j++) begin
         if (bitv != 0) begin
            if (v >= r + bitv) begin
               v = v - (r + bitv);
               r = (r >> 1) + bitv;
            end else begin
               r = r >> 1;
            end
            bitv = bitv >> 2;
         end
      end
      return r;
   endfunction

   // Inverse CORDIC gain in Q32 for a given number of steps.
   function automatic logic [63:0] inv_gain_q32(input int iters);
      logic [63:0] p;
      logic [63:0] s;
      p = 64'd1 << 62;
      for (int i = 0; i < iters; i++) begin
         if (2 * i < 64) begin
            p = p + (p >> (2 * i));
         end
      end
      s = isqrt64(p);
      if (s == 0) begin
         s = 64'd1;
      end
      return udiv64((64'd1 << 63) + (s >> 1), s);
   endfunction

endpackage

`default_nettype wire

// File: src/c2p_cordic_stage.sv
// One registered vectoring-mode CORDIC micro-rotation with elastic handshake.
// Depends on c2p_pkg.
`default_nettype none

module c2p_cordic_stage #(
   parameter int          SHIFT = 0,
   parameter logic [63:0] ATAN  = '0
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  c2p_pkg::c2p_vec_type in_vec,
   output logic                 out_valid,
   input  wire                  out_ready,
   output c2p_pkg::c2p_vec_type out_vec
);
   import c2p_pkg::*;

   logic        valid_ff;
   c2p_vec_type vec_ff;
   c2p_vec_type vec_in;
   logic signed [XY_W-1:0] dx;
   logic signed [XY_W-1:0] dy;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      dx     = $signed(in_vec.x) >>> SHIFT;
      dy     = $signed(in_vec.y) >>> SHIFT;
      vec_in = in_vec;
      // y of zero counts as non-negative
      if (!in_vec.y[XY_W-1]) begin
         vec_in.x = in_vec.x + dy;
         vec_in.y = in_vec.y - dx;
         vec_in.z = in_vec.z + ATAN;
      end else begin
         vec_in.x = in_vec.x - dy;
         vec_in.y = in_vec.y + dx;
         vec_in.z = in_vec.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

`default_nettype wire

// File: src/c2p_gain.sv
// Gain correction, rounding and saturation: three registered stages that turn
// the final CORDIC vector into magnitude and angle. Depends on c2p_pkg.
`default_nettype none

module c2p_gain #(
   parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               in_valid,
   output logic                              in_ready,
   input  c2p_pkg::c2p_vec_type              in_vec,
   output logic                              out_valid,
   input  wire                               out_ready,
   output logic [c2p_pkg::MAG_W-1:0]         out_mag,
   output logic signed [c2p_pkg::ANG_W-1:0]  out_ang,
   output logic                              out_last
);
   import c2p_pkg::*;

   localparam logic [63:0] K_FULL = inv_gain_q32(ITERATIONS);
   localparam logic [31:0] K      = K_FULL[31:0];
   localparam int AH_W  = XY_W - 32;
   localparam int HI_W  = AH_W + 32;
   localparam int T_W   = HI_W + 1;
   localparam int MF_W  = T_W - 24;

   localparam logic signed [31:0] ANG_MAX = 32'(ANGLE_LIMIT);
   localparam logic signed [31:0] ANG_MIN = -32'(ANGLE_LIMIT);

   logic en1, en2, en3;
   logic v1_ff, v2_ff, v3_ff;

   // stage 1: low partial product
   logic [63:0]     lo1_ff, lo1_in;
   logic [AH_W-1:0] ah1_ff;
   logic [Z_W-1:0]  z1_ff;
   logic            zero1_ff, last1_ff;
   // stage 2: high partial product
   logic [63:0]     lo2_ff;
   logic [HI_W-1:0] hi2_ff, hi2_in;
   logic [Z_W-1:0]  z2_ff;
   logic            zero2_ff, last2_ff;
   // stage 3: round, saturate
   logic [MAG_W-1:0]        mag3_ff, mag3_in;
   logic signed [ANG_W-1:0] ang3_ff, ang3_in;
   logic                    last3_ff;

   logic [64:0]        lo_rnd;
   logic [T_W-1:0]     t_sum;
   logic [MF_W-1:0]    mag_full;
   logic [Z_W-1:0]     z_rnd;
   logic signed [31:0] ang32;

   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   assign lo1_in = 64'(in_vec.x[31:0]) * 64'(K);
   assign hi2_in = HI_W'(ah1_ff) * HI_W'(K);

   always_comb begin
      // x*K + 2^55, then >> 56, split across the two partial products
      lo_rnd   = 65'(lo2_ff) + (65'd1 << 55);
      t_sum    = T_W'(hi2_ff) + T_W'(lo_rnd[64:32]);
      mag_full = t_sum[T_W-1:24];
      if (mag_full > MF_W'(MAG_LIMIT)) begin
         mag3_in = MAG_LIMIT;
      end else begin
         mag3_in = mag_full[MAG_W-1:0];
      end

      z_rnd = z2_ff + (64'd1 << 31);
      ang32 = $signed(z_rnd[63:32]);
      if (ang32 > ANG_MAX) begin
         ang3_in = ANG_MAX[ANG_W-1:0];
      end else if (ang32 < ANG_MIN) begin
         ang3_in = ANG_MIN[ANG_W-1:0];
      end else begin
         ang3_in = ang32[ANG_W-1:0];
      end

      if (zero2_ff) begin
         mag3_in = '0;
         ang3_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         lo1_ff   <= lo1_in;
         ah1_ff   <= in_vec.x[XY_W-1:32];
         z1_ff    <= in_vec.z;
         zero1_ff <= in_vec.zero;
         last1_ff <= in_vec.last;
      end
      if (en2 && v1_ff) begin
         lo2_ff   <= lo1_ff;
         hi2_ff   <= hi2_in;
         z2_ff    <= z1_ff;
         zero2_ff <= zero1_ff;
         last2_ff <= last1_ff;
      end
      if (en3 && v2_ff) begin
         mag3_ff  <= mag3_in;
         ang3_ff  <= ang3_in;
         last3_ff <= last2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_mag   = mag3_ff;
   assign out_ang   = ang3_ff;
   assign out_last  = last3_ff;

   // final CORDIC x must never be negative: the split multiply treats it unsigned
   a_x_nonneg: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !in_vec.zero) |-> !in_vec.x[XY_W-1])
      else $error("final x negative");

   a_mag_limit: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (mag3_ff <= MAG_LIMIT))
      else $error("magnitude above limit");

   a_ang_limit: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((32'(ang3_ff) <= ANG_MAX) && (32'(ang3_ff) >= ANG_MIN)))
      else $error("angle out of range");

endmodule

`default_nettype wire

// File: src/cartesian_to_polar_core.sv
// Cartesian-to-polar converter: pre-rotation stage, unrolled CORDIC stages and
// gain correction. Depends on c2p_pkg, c2p_cordic_stage, c2p_gain.
//
//   channel | direction | tdata (low bit up)                  | tlast
//   req     | in        | x_coord[31:0], y_coord[31:0]         | last_in
//   rsp     | out       | magnitude[31:0], angle[30:0], 0 pad  | last_out
//
// One item per clock sustained while rsp is not stalled; one pre-rotation stage,
// one register per CORDIC step, and three gain/rounding stages.
// Every stage holds an item with its own valid bit; a stage takes a new item
// when it is empty or the next one moves, so bubbles close up under a stall.
// Reset clears only the valid bits.
`default_nettype none

module cartesian_to_polar_core #(
   parameter int ITERATIONS = c2p_pkg::ITERATIONS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // x_coord[31:0], y_coord[63:32]
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // magnitude[31:0], angle[62:32], 0 pad[63]
   output logic        rsp_tlast
);
   import c2p_pkg::*;

   localparam int EXT_W = XY_W - 32 - GUARD_W;

   logic        pre_valid_ff;
   c2p_vec_type pre_vec_ff;
   c2p_vec_type pre_vec_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;

   logic        stage_valid [ITERATIONS+1];
   logic        stage_ready [ITERATIONS+1];
   c2p_vec_type stage_vec   [ITERATIONS+1];

   logic [MAG_W-1:0]        mag;
   logic signed [ANG_W-1:0] ang;

   always_comb begin
      xs = {{EXT_W{req_tdata[31]}}, req_tdata[31:0], {GUARD_W{1'b0}}};
      ys = {{EXT_W{req_tdata[63]}}, req_tdata[63:32], {GUARD_W{1'b0}}};
      pre_vec_in.x    = xs;
      pre_vec_in.y    = ys;
      pre_vec_in.z    = '0;
      pre_vec_in.zero = (req_tdata == 64'd0);
      pre_vec_in.last = req_tlast;
      // quarter turn into the right half plane
      if (xs[XY_W-1]) begin
         if (!ys[XY_W-1]) begin
            pre_vec_in.x = ys;
            pre_vec_in.y = -xs;
            pre_vec_in.z = PI_HALF_Q60;
         end else begin
            pre_vec_in.x = -ys;
            pre_vec_in.y = xs;
            pre_vec_in.z = -PI_HALF_Q60;
         end
      end
   end

   assign req_tready = !pre_valid_ff || stage_ready[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (req_tready) begin
         pre_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         pre_vec_ff <= pre_vec_in;
      end
   end

   assign stage_valid[0] = pre_valid_ff;
   assign stage_vec[0]   = pre_vec_ff;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
      c2p_cordic_stage #(
         .SHIFT (i),
         .ATAN  (atan_q60(i))
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_vec    (stage_vec[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_vec   (stage_vec[i+1])
      );
   end

   c2p_gain #(
      .ITERATIONS (ITERATIONS)
   ) u_gain (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[ITERATIONS]),
      .in_ready  (stage_ready[ITERATIONS]),
      .in_vec    (stage_vec[ITERATIONS]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_mag   (mag),
      .out_ang   (ang),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, ang, mag};

   a_pre_right_half: assert property (@(posedge clock) disable iff (reset)
      pre_valid_ff |-> !pre_vec_ff.x[XY_W-1])
      else $error("pre-rotation left x negative");

   a_origin_flag: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tdata == 64'd0) |=> (pre_valid_ff && pre_vec_ff.zero))
      else $error("origin item not flagged");

   a_pre_hold: assert property (@(posedge clock) disable iff (reset)
      (pre_valid_ff && !stage_ready[0]) |=> (pre_valid_ff && $stable(pre_vec_ff)))
      else $error("pre-rotation stage lost a stalled item");

endmodule

`default_nettype wire

// File: tb/cartesian_to_polar_core_tb.sv
// Testbench for cartesian_to_polar_core: streams points, predicts magnitude and
// angle with a bit-exact vectoring CORDIC model and checks every result item.
// Depends on c2p_pkg and cartesian_to_polar_core.
`timescale 1ns / 100ps

module cartesian_to_polar_core_tb;

   localparam int ITERATIONS   = c2p_pkg::ITERATIONS_DEFAULT;
   localparam int LATENCY      = ITERATIONS + 4;
   localparam int QUIET_LIMIT  = 5000;
   localparam int REPORT_LIMIT = 200;

   localparam longint PI_HALF        = 64'h1921FB54442D1846;   // Q60
   localparam longint PI_QUARTER     = 64'h0C90FDAA22168C23;   // Q60
   localparam longint ANG_SAT        = 843314857;               // pi in Q28
   localparam logic [31:0] MAG_SAT   = 32'd3037000500;
   localparam logic signed [31:0] XY_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] XY_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic [31:0] magnitude;
      logic [30:0] angle;
      logic        last;
   } polar_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // x_coord[31:0], y_coord[63:32]
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // magnitude[31:0], angle[62:32], pad[63]
   logic        rsp_tlast;

   polar_result_type expected_points[$];
   longint           atan_tbl[ITERATIONS];
   logic [31:0]      inv_gain;
   int               mismatch_count = 0;
   int               send_idle_pct  = 0;
   int               rsp_idle_pct   = 0;
   int               rsp_hold_len   = 0;
   int               quiet_cycles   = 0;

   cartesian_to_polar_core #(
      .ITERATIONS(ITERATIONS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // arctangent table (Q60) and inverse gain (Q32)
   initial begin : cordic_constants
      longint unsigned gain;
      longint unsigned root;
      longint unsigned trial;
      longint unsigned term;
      for (int i = 0; i < ITERATIONS; i++) begin
         if (i == 0) begin
            atan_tbl[i] = PI_QUARTER;
         end else begin
            atan_tbl[i] = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
               term = (64'd1 << (60 - i * (2 * k + 1))) / longint'(2 * k + 1);
               if (k % 2 == 1) begin
                  atan_tbl[i] = atan_tbl[i] - longint'(term);
               end else begin
                  atan_tbl[i] = atan_tbl[i] + longint'(term);
               end
            end
         end
      end
      gain = 64'd1 << 62;
      for (int i = 0; i < ITERATIONS; i++) begin
         if (2 * i < 64) begin
            gain = gain + (gain >> (2 * i));
         end
      end
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= gain) begin
            root = trial;
         end
      end
      if (root == 0) begin
         root = 1;
      end
      inv_gain = 32'(((64'd1 << 63) + (root >> 1)) / root);
   end

   function automatic polar_result_type polar_of(input logic signed [31:0] xc,
                                                 input logic signed [31:0] yc,
                                                 input logic last);
      longint           x;
      longint           y;
      longint           z;
      longint           nx;
      longint           dx;
      longint           dy;
      longint           ang;
      logic [127:0]     prod;
      polar_result_type r;
      r.last = last;
      if (xc == 0 && yc == 0) begin
         r.magnitude = '0;
         r.angle     = '0;
         return r;
      end
      x = longint'(xc) <<< 24;
      y = longint'(yc) <<< 24;
      z = 0;
      // fold the left half plane onto the right one
      if (x < 0) begin
         if (y >= 0) begin
            nx = y;
            y  = -x;
            z  = PI_HALF;
         end else begin
            nx = -y;
            y  = x;
            z  = -PI_HALF;
         end
         x = nx;
      end
      for (int i = 0; i < ITERATIONS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x = x + dy;
            y = y - dx;
            z = z + atan_tbl[i];
         end else begin
            x = x - dy;
            y = y + dx;
            z = z - atan_tbl[i];
         end
      end
      prod = {64'd0, x} * {96'd0, inv_gain};
      prod = prod + (128'd1 << 55);
      if (prod[127:56] > MAG_SAT) begin
         r.magnitude = MAG_SAT;
      end else begin
         r.magnitude = prod[87:56];
      end
      ang = (z + 64'sh0000_0000_8000_0000) >>> 32;
      if (ang > ANG_SAT) begin
         ang = ANG_SAT;
      end else if (ang < -ANG_SAT) begin
         ang = -ANG_SAT;
      end
      r.angle = ang[30:0];
      return r;
   endfunction

   task automatic offer_point(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      expected_points.push_back(polar_of(x, y, last));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_points.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // extremes, axes, origin, the +-pi boundary and saturation corners
   task automatic test_directed_points();
      offer_point(0, 0, 1'b0);
      offer_point(0, 0, 1'b1);
      offer_point(XY_MAX, 0, 1'b0);
      offer_point(XY_MIN, 0, 1'b0);
      offer_point(0, XY_MAX, 1'b1);
      offer_point(0, XY_MIN, 1'b0);
      offer_point(XY_MAX, XY_MAX, 1'b0);
      offer_point(XY_MIN, XY_MIN, 1'b0);
      offer_point(XY_MIN, XY_MAX, 1'b0);
      offer_point(XY_MAX, XY_MIN, 1'b1);
      offer_point(-1, 0, 1'b0);
      offer_point(1, 0, 1'b0);
      offer_point(0, 1, 1'b0);
      offer_point(0, -1, 1'b0);
      offer_point(-1, -1, 1'b0);
      offer_point(-1, 1, 1'b1);
      offer_point(1, -1, 1'b0);
      offer_point(1, 1, 1'b0);
      offer_point(XY_MIN, -1, 1'b0);
      offer_point(XY_MIN, 1, 1'b0);
      offer_point(-65536, 0, 1'b0);
      offer_point(65536, 65536, 1'b0);
      offer_point(32'sh5555_5555, 32'shAAAA_AAAA, 1'b0);
      offer_point(32'shAAAA_AAAA, 32'sh5555_5555, 1'b1);
      wait_for_results();
   endtask

   task automatic test_random_points(input int sender_pct, input int receiver_pct,
                                     input int count);
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] a;
      send_idle_pct = sender_pct;
      rsp_idle_pct  = receiver_pct;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               x = $urandom;
               y = $urandom;
            end
            4, 5: begin
               x = $urandom_range(0, 2 ** 21) - 2 ** 20;
               y = $urandom_range(0, 2 ** 21) - 2 ** 20;
            end
            6: begin
               if ($urandom_range(0, 1)) begin
                  x = $urandom;
                  y = 0;
               end else begin
                  x = 0;
                  y = $urandom;
               end
            end
            7: begin
               a = $urandom_range(0, 32'h7FFF_FFFF);
               x = $urandom_range(0, 1) ? a : -a;
               y = $urandom_range(0, 1) ? a : -a;
            end
            8: begin
               x = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
               y = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom)};
            end
            default: begin
               x = $urandom_range(0, 6) - 3;
               y = $urandom_range(0, 6) - 3;
            end
         endcase
         offer_point(x, y, $urandom_range(0, 7) == 0);
         // sender pause: let the whole pipeline empty out
         if (n == count / 2) begin
            wait_for_results();
         end
      end
      wait_for_results();
   endtask

   // receiver holds off long enough for the pipeline to fill and stall req
   task automatic test_output_stall();
      int saved_pct;
      saved_pct     = send_idle_pct;
      send_idle_pct = 0;
      rsp_hold_len  = 300;
      for (int n = 0; n < 80; n++) begin
         offer_point($urandom, $urandom, $urandom_range(0, 1) == 1);
      end
      wait_for_results();
      send_idle_pct = saved_pct;
   endtask

   initial begin : rsp_driver
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len != 0) begin
            hold_left    = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      polar_result_type want;
      logic [30:0]      got_angle;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_angle = rsp_tdata[62:32];
         if (expected_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("%0t: expected no item, actual magnitude %0d angle %0d last %0b",
                        $time, rsp_tdata[31:0], $signed(got_angle), rsp_tlast);
            end
         end else begin
            want = expected_points.pop_front();
            if (want.magnitude !== rsp_tdata[31:0] || want.angle !== got_angle ||
                want.last !== rsp_tlast) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $write("%0t: expected magnitude %0d angle %0d last %0b, ",
                         $time, want.magnitude, $signed(want.angle), want.last);
                  $display("actual magnitude %0d angle %0d last %0b",
                           rsp_tdata[31:0], $signed(got_angle), rsp_tlast);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 10;
      rsp_idle_pct  = 70;
      test_directed_points();
      test_output_stall();
      test_random_points(10, 70, 280);
      test_random_points(70, 10, 280);
      test_random_points(0, 0, 280);

      wait_for_results();
      repeat (LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: cartesian_to_polar_core.f
src/c2p_pkg.sv
src/c2p_cordic_stage.sv
src/c2p_gain.sv
src/cartesian_to_polar_core.sv
tb/cartesian_to_polar_core_tb.sv
